/* hw/rtl/packet_header_field_extractor_unit_defines.svh */
// Assertion macros for the packet header field extractor.
// No dependencies; included by the top level.
`ifndef PACKET_HEADER_FIELD_EXTRACTOR_UNIT_DEFINES_SVH
`define PACKET_HEADER_FIELD_EXTRACTOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define PHFE_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PHFE_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> nxt) else $error(msg);
`else
`define PHFE_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define PHFE_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

/* hw/rtl/phfe_pkg.sv */
// Types and constants for the packet header field extractor.
// No dependencies.
package phfe_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_tag;
        logic [63:0] field_value;
        logic        frame_done;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_ETH  = 3'd0,
        ST_IPV4 = 3'd1,
        ST_OPTS = 3'd2,
        ST_IPV6 = 3'd3,
        ST_TCP  = 3'd4,
        ST_UDP  = 3'd5,
        ST_SKIP = 3'd6
    } stage_t;

    typedef enum logic [3:0] {
        CMD_ETH  = 4'd0,
        CMD_IPV4 = 4'd1,
        CMD_IPV6 = 4'd2,
        CMD_TCP  = 4'd3,
        CMD_UDP  = 4'd4,
        CMD_NONE = 4'd5
    } cmd_t;

    localparam int unsigned HDR_DEPTH = 40;
    localparam int unsigned QDEPTH    = 4;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;
    localparam logic [15:0] ET_IPV4 = 16'h0800;
    localparam logic [15:0] ET_IPV6 = 16'h86dd;
    localparam logic [15:0] ET_ARP  = 16'h0806;

    localparam logic [3:0] S_DONE = 4'd0;
    localparam logic [3:0] S_ETH  = 4'd1;
    localparam logic [3:0] S_IPV4 = 4'd2;
    localparam logic [3:0] S_IPV6 = 4'd3;
    localparam logic [3:0] S_TCP  = 4'd4;
    localparam logic [3:0] S_UDP  = 4'd5;
    localparam logic [3:0] S_ARP  = 4'd6;
    localparam logic [3:0] S_UNK  = 4'd7;
    localparam logic [3:0] S_UNK4 = 4'd8;
    localparam logic [3:0] S_UNK6 = 4'd9;

    localparam logic [4:0] TAG_DST_MAC   = 5'd0;
    localparam logic [4:0] TAG_SRC_MAC   = 5'd1;
    localparam logic [4:0] TAG_ETYPE     = 5'd2;
    localparam logic [4:0] TAG_V4_SRC    = 5'd3;
    localparam logic [4:0] TAG_V4_DST    = 5'd4;
    localparam logic [4:0] TAG_V4_PROTO  = 5'd5;
    localparam logic [4:0] TAG_V6_NXT    = 5'd6;
    localparam logic [4:0] TAG_V6_SRC_H  = 5'd7;
    localparam logic [4:0] TAG_V6_SRC_L  = 5'd8;
    localparam logic [4:0] TAG_V6_DST_H  = 5'd9;
    localparam logic [4:0] TAG_V6_DST_L  = 5'd10;
    localparam logic [4:0] TAG_TCP_SPORT = 5'd11;
    localparam logic [4:0] TAG_TCP_DPORT = 5'd12;
    localparam logic [4:0] TAG_TCP_SEQ   = 5'd13;
    localparam logic [4:0] TAG_TCP_ACK   = 5'd14;
    localparam logic [4:0] TAG_TCP_OFF   = 5'd15;
    localparam logic [4:0] TAG_TCP_FLAGS = 5'd16;
    localparam logic [4:0] TAG_TCP_WIN   = 5'd17;
    localparam logic [4:0] TAG_TCP_CSUM  = 5'd18;
    localparam logic [4:0] TAG_TCP_URG   = 5'd19;
    localparam logic [4:0] TAG_UDP_SPORT = 5'd20;
    localparam logic [4:0] TAG_UDP_DPORT = 5'd21;
    localparam logic [4:0] TAG_STATUS    = 5'd22;

    // one job for the emitter: a completed header snapshot and/or a status
    typedef struct packed {
        cmd_t         cmd;
        logic [319:0] hdr;
        logic         has_status;
        logic [3:0]   status;
    } job_t;
endpackage

/* hw/rtl/packet_header_field_extractor_unit.sv */
// Packet header field extractor, top level.
// Depends on phfe_pkg, phfe_front, phfe_queue, phfe_emit and the defines header.
//
// Input channel: one frame byte per transaction with an end-of-frame mark.
// Output channel: tagged field transactions (tag, 64-bit value, frame_done).
// A byte is taken every cycle while the 4-entry job queue has room; the
// front end snapshots a header as it completes and queues one job for it.
// The emitter turns a job into its fields at one result per cycle while the
// receiver does not stall: the header's job is written into the queue, and the
// first field then passes through the output register; the others follow it.
// Sustained rate is one byte per cycle; it drops only when field bursts
// (up to 10 per job) fill the queue, which then stalls the input.
// Reset clears position, stage and queue; the block starts at the
// Ethernet header. A stalled receiver holds the output register; jobs
// back up in the queue and then the input stalls.
`include "packet_header_field_extractor_unit_defines.svh"
module packet_header_field_extractor_unit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  phfe_pkg::in_item_t  in_item,
    output logic                in_stall,
    output logic                out_valid,
    output phfe_pkg::out_item_t out_item,
    input  logic                out_stall
);
    logic           fj_valid;
    phfe_pkg::job_t fj;
    logic           q_full;
    logic           q_valid;
    phfe_pkg::job_t qj;
    logic           q_pop;

    phfe_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_stall  (in_stall),
        .job_valid (fj_valid),
        .job       (fj),
        .q_full    (q_full)
    );

    phfe_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fj_valid),
        .wr_job   (fj),
        .full     (q_full),
        .rd_valid (q_valid),
        .rd_job   (qj),
        .rd_en    (q_pop)
    );

    phfe_emit u_emit
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (qj),
        .job_pop   (q_pop),
        .out_valid (out_valid),
        .out_item  (out_item),
        .out_stall (out_stall)
    );

    `PHFE_ASSERT_IMPL(a_no_write_full, clk, rst_n, !(fj_valid && q_full), "queue overflow")
    `PHFE_ASSERT_IMPL(a_pop_valid, clk, rst_n, !(q_pop && !q_valid), "pop from empty queue")
    `PHFE_ASSERT_NEXT(a_done_tag, clk, rst_n, 1'b1, (!out_item.frame_done || out_item.field_tag == phfe_pkg::TAG_STATUS) || !out_valid, "done mark on non-status")
endmodule

/* hw/rtl/phfe_front.sv */
// Front end: tracks header position, buffers header bytes, decides the layer.
// Depends on phfe_pkg.
module phfe_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  phfe_pkg::in_item_t in_item,
    output logic               in_stall,
    output logic               job_valid,
    output phfe_pkg::job_t     job,
    input  logic               q_full
);
    logic [7:0]       pos_reg, pos_next;
    phfe_pkg::stage_t stage_reg, stage_next;
    logic [5:0]       ihl_reg, ihl_next;
    logic [3:0]       fstat_reg, fstat_next;
    logic [7:0]       hdr_reg [phfe_pkg::HDR_DEPTH];
    logic [7:0]       p9_reg;
    logic [319:0]     snap;
    logic             acc;
    logic [7:0]       b;
    logic [7:0]       np;
    logic [15:0]      et;
    logic [7:0]       proto;
    logic [5:0]       hl;
    phfe_pkg::cmd_t   cmd;
    logic [3:0]       code;

    assign in_stall = q_full;
    assign acc = in_valid && !q_full;
    assign b = in_item.data_byte;
    assign np = (pos_reg == 8'd255) ? pos_reg : pos_reg + 8'd1;

    always_comb
    begin
        for (int i = 0; i < 40; i++)
        begin
            snap[319 - 8*i -: 8] = hdr_reg[i];
            if (pos_reg == 8'(i))
            begin
                snap[319 - 8*i -: 8] = b;
            end
        end
    end

    assign et = snap[319 - 96 -: 16];
    assign hl = {b[3:0], 2'b00};

    always_comb
    begin
        stage_next = stage_reg;
        pos_next = np;
        ihl_next = ihl_reg;
        fstat_next = fstat_reg;
        cmd = phfe_pkg::CMD_NONE;
        proto = 8'd0;
        case (stage_reg)
            phfe_pkg::ST_ETH:
            begin
                if (np == 8'd14)
                begin
                    cmd = phfe_pkg::CMD_ETH;
                    pos_next = 8'd0;
                    if (et == phfe_pkg::ET_IPV4)
                    begin
                        stage_next = phfe_pkg::ST_IPV4;
                    end
                    else if (et == phfe_pkg::ET_IPV6)
                    begin
                        stage_next = phfe_pkg::ST_IPV6;
                    end
                    else
                    begin
                        stage_next = phfe_pkg::ST_SKIP;
                        pos_next = np;
                        fstat_next = (et == phfe_pkg::ET_ARP) ? phfe_pkg::S_ARP
                                                               : phfe_pkg::S_UNK;
                    end
                end
            end
            phfe_pkg::ST_IPV4:
            begin
                proto = snap[319 - 72 -: 8];
                if (np == 8'd1)
                begin
                    ihl_next = (hl < 6'd20) ? 6'd20 : hl;
                end
                else if (np == 8'd20)
                begin
                    cmd = phfe_pkg::CMD_IPV4;
                    if (proto != phfe_pkg::PROTO_TCP && proto != phfe_pkg::PROTO_UDP)
                    begin
                        stage_next = phfe_pkg::ST_SKIP;
                        fstat_next = phfe_pkg::S_UNK4;
                    end
                    else if (ihl_reg > 6'd20)
                    begin
                        stage_next = phfe_pkg::ST_OPTS;
                    end
                    else
                    begin
                        pos_next = 8'd0;
                        stage_next = (proto == phfe_pkg::PROTO_TCP) ? phfe_pkg::ST_TCP
                                                                    : phfe_pkg::ST_UDP;
                    end
                end
            end
            phfe_pkg::ST_OPTS:
            begin
                if (np >= {2'b00, ihl_reg})
                begin
                    pos_next = 8'd0;
                    stage_next = (p9_reg == phfe_pkg::PROTO_TCP) ? phfe_pkg::ST_TCP
                                                                 : phfe_pkg::ST_UDP;
                end
            end
            phfe_pkg::ST_IPV6:
            begin
                proto = snap[319 - 48 -: 8];
                if (np == 8'd40)
                begin
                    cmd = phfe_pkg::CMD_IPV6;
                    if (proto == phfe_pkg::PROTO_TCP || proto == phfe_pkg::PROTO_UDP)
                    begin
                        pos_next = 8'd0;
                        stage_next = (proto == phfe_pkg::PROTO_TCP) ? phfe_pkg::ST_TCP
                                                                    : phfe_pkg::ST_UDP;
                    end
                    else
                    begin
                        stage_next = phfe_pkg::ST_SKIP;
                        fstat_next = phfe_pkg::S_UNK6;
                    end
                end
            end
            phfe_pkg::ST_TCP:
            begin
                if (np == 8'd20)
                begin
                    cmd = phfe_pkg::CMD_TCP;
                    stage_next = phfe_pkg::ST_SKIP;
                    fstat_next = phfe_pkg::S_DONE;
                end
            end
            phfe_pkg::ST_UDP:
            begin
                if (np == 8'd8)
                begin
                    cmd = phfe_pkg::CMD_UDP;
                    stage_next = phfe_pkg::ST_SKIP;
                    fstat_next = phfe_pkg::S_DONE;
                end
            end
            default:
            begin
            end
        endcase

        case (stage_next)
            phfe_pkg::ST_ETH:  code = phfe_pkg::S_ETH;
            phfe_pkg::ST_IPV4: code = phfe_pkg::S_IPV4;
            phfe_pkg::ST_OPTS: code = (p9_reg == phfe_pkg::PROTO_TCP) ? phfe_pkg::S_TCP
                                                                      : phfe_pkg::S_UDP;
            phfe_pkg::ST_IPV6: code = phfe_pkg::S_IPV6;
            phfe_pkg::ST_TCP:  code = phfe_pkg::S_TCP;
            phfe_pkg::ST_UDP:  code = phfe_pkg::S_UDP;
            default:           code = fstat_next;
        endcase

        if (in_item.end_of_frame)
        begin
            stage_next = phfe_pkg::ST_ETH;
            pos_next = 8'd0;
            ihl_next = 6'd20;
            fstat_next = phfe_pkg::S_DONE;
        end
    end

    assign job_valid = acc && (cmd != phfe_pkg::CMD_NONE || in_item.end_of_frame);
    assign job.cmd = cmd;
    assign job.hdr = snap;
    assign job.has_status = in_item.end_of_frame;
    assign job.status = code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 8'd0;
            stage_reg <= phfe_pkg::ST_ETH;
            ihl_reg <= 6'd20;
            fstat_reg <= phfe_pkg::S_DONE;
        end
        else if (acc)
        begin
            pos_reg <= pos_next;
            stage_reg <= stage_next;
            ihl_reg <= ihl_next;
            fstat_reg <= fstat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc && pos_reg < 8'd40)
        begin
            hdr_reg[pos_reg[5:0]] <= b;
        end
        if (acc && stage_reg == phfe_pkg::ST_IPV4 && pos_reg == 8'd9)
        begin
            p9_reg <= b;
        end
    end
endmodule

/* hw/rtl/phfe_queue.sv */
// Job queue between the front end and the field emitter.
// Depends on phfe_pkg.
module phfe_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  phfe_pkg::job_t wr_job,
    output logic           full,
    output logic           rd_valid,
    output phfe_pkg::job_t rd_job,
    input  logic           rd_en
);
    phfe_pkg::job_t mem_reg [phfe_pkg::QDEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full = (cnt_reg == 3'(phfe_pkg::QDEPTH));
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_job = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wp_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 2'd0;
            rp_reg <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (wr_en)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (rd_en)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + 3'(wr_en) - 3'(rd_en);
        end
    end
endmodule

/* hw/rtl/phfe_emit.sv */
// Back end: expands one job into tagged field results, one per cycle unless the output stalls.
// Depends on phfe_pkg.
module phfe_emit
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  phfe_pkg::job_t      job,
    output logic                job_pop,
    output logic                out_valid,
    output phfe_pkg::out_item_t out_item,
    input  logic                out_stall
);
    logic [3:0]  idx_reg;
    logic [3:0]  nf;
    logic [4:0]  base;
    logic        last;
    logic [4:0]  tag;
    logic [63:0] val;
    logic        done;
    logic        take;
    logic        ov_reg;
    phfe_pkg::out_item_t oi_reg;
    logic [319:0] h;

    assign h = job.hdr;

    function automatic logic [7:0] hb(input logic [319:0] x, input int k);
        hb = x[319 - 8*k -: 8];
    endfunction

    always_comb
    begin
        case (job.cmd)
            phfe_pkg::CMD_ETH:  begin nf = 4'd3; base = phfe_pkg::TAG_DST_MAC;   end
            phfe_pkg::CMD_IPV4: begin nf = 4'd3; base = phfe_pkg::TAG_V4_SRC;    end
            phfe_pkg::CMD_IPV6: begin nf = 4'd5; base = phfe_pkg::TAG_V6_NXT;    end
            phfe_pkg::CMD_TCP:  begin nf = 4'd9; base = phfe_pkg::TAG_TCP_SPORT; end
            phfe_pkg::CMD_UDP:  begin nf = 4'd2; base = phfe_pkg::TAG_UDP_SPORT; end
            default:            begin nf = 4'd0; base = phfe_pkg::TAG_DST_MAC;   end
        endcase
        done = (idx_reg == nf);
        last = job.has_status ? done : (idx_reg + 4'd1 == nf);
        tag = done ? phfe_pkg::TAG_STATUS : base + 5'(idx_reg);
        val = 64'd0;
        case (tag)
            phfe_pkg::TAG_DST_MAC:   val = {16'd0, h[319 -: 48]};
            phfe_pkg::TAG_SRC_MAC:   val = {16'd0, h[319 - 48 -: 48]};
            phfe_pkg::TAG_ETYPE:     val = {48'd0, h[319 - 96 -: 16]};
            phfe_pkg::TAG_V4_SRC:    val = {32'd0, h[319 - 96 -: 32]};
            phfe_pkg::TAG_V4_DST:    val = {32'd0, h[319 - 128 -: 32]};
            phfe_pkg::TAG_V4_PROTO:  val = {56'd0, hb(h, 9)};
            phfe_pkg::TAG_V6_NXT:    val = {56'd0, hb(h, 6)};
            phfe_pkg::TAG_V6_SRC_H:  val = h[319 - 64 -: 64];
            phfe_pkg::TAG_V6_SRC_L:  val = h[319 - 128 -: 64];
            phfe_pkg::TAG_V6_DST_H:  val = h[319 - 192 -: 64];
            phfe_pkg::TAG_V6_DST_L:  val = h[319 - 256 -: 64];
            phfe_pkg::TAG_TCP_SPORT: val = {48'd0, h[319 -: 16]};
            phfe_pkg::TAG_TCP_DPORT: val = {48'd0, h[319 - 16 -: 16]};
            phfe_pkg::TAG_TCP_SEQ:   val = {32'd0, h[319 - 32 -: 32]};
            phfe_pkg::TAG_TCP_ACK:   val = {32'd0, h[319 - 64 -: 32]};
            phfe_pkg::TAG_TCP_OFF:   val = {60'd0, h[319 - 96 -: 4]};
            phfe_pkg::TAG_TCP_FLAGS: val = {56'd0, hb(h, 13)};
            phfe_pkg::TAG_TCP_WIN:   val = {48'd0, h[319 - 112 -: 16]};
            phfe_pkg::TAG_TCP_CSUM:  val = {48'd0, h[319 - 128 -: 16]};
            phfe_pkg::TAG_TCP_URG:   val = {48'd0, h[319 - 144 -: 16]};
            phfe_pkg::TAG_UDP_SPORT: val = {48'd0, h[319 -: 16]};
            phfe_pkg::TAG_UDP_DPORT: val = {48'd0, h[319 - 16 -: 16]};
            default:                 val = {60'd0, job.status};
        endcase
    end

    assign take = job_valid && (!ov_reg || !out_stall);
    assign job_pop = take && last;
    assign out_valid = ov_reg;
    assign out_item = oi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            idx_reg <= 4'd0;
        end
        else
        begin
            if (take)
            begin
                ov_reg <= 1'b1;
                idx_reg <= last ? 4'd0 : idx_reg + 4'd1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            oi_reg.field_tag <= tag;
            oi_reg.field_value <= val;
            oi_reg.frame_done <= done;
        end
    end
endmodule
